>>> rtl/core/trrb_pkg.sv
package trrb_pkg;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_WRITE  = 3'd1,
    OP_SEEK   = 3'd2,
    OP_NEXT   = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ORDER = 2'd1,
    ST_LONG  = 2'd2,
    ST_NONE  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISP,
    S_EV_CHK,
    S_EV_UPD,
    S_LINK,
    S_PLACE,
    S_SK_ISS,
    S_SK_EVAL,
    S_NX_EVAL,
    S_NX_OUT,
    S_RD_EVAL,
    S_RD_OUT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] stamp;
    logic [11:0] message_length;
    logic [7:0]  byte_value;
    logic [11:0] record_offset;
    logic [11:0] byte_index;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] found_offset;
    logic [63:0] found_stamp;
    logic [11:0] found_length;
    logic [7:0]  read_value;
  } out_t;

endpackage

>>> rtl/core/timestamped_record_ring_buffer.sv
// Timing: an append takes longer for each evicted record and a seek for each
// record walked; the header memory's single read port, a registered read, sets
// the pace of each chain step.
// Throughput: one item at a time; the next item is taken once the result is staged.
// Reset: control state clears at once, then a clearing pass over every header
// entry zeroes the header memory, during which no item is accepted.
module timestamped_record_ring_buffer
  import trrb_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = 4096,
  parameter int unsigned HEADER_BYTES = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned HW = AW + 77;

  logic          res_valid, res_ready;
  out_t          res;
  logic          out_valid_q;
  out_t          out_q;

  logic          hdr_we, hdr_re;
  logic [AW-1:0] hdr_waddr, hdr_raddr;
  logic [HW-1:0] hdr_wdata, hdr_rdata;
  logic          byte_we, byte_re;
  logic [AW-1:0] byte_waddr, byte_raddr;
  logic [7:0]    byte_wdata, byte_rdata;

  // The sequencer walks the record chain through the header memory.
  trrb_ctrl #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .hdr_we_o    (hdr_we),
    .hdr_waddr_o (hdr_waddr),
    .hdr_wdata_o (hdr_wdata),
    .hdr_re_o    (hdr_re),
    .hdr_raddr_o (hdr_raddr),
    .hdr_rdata_i (hdr_rdata),
    .byte_we_o   (byte_we),
    .byte_waddr_o(byte_waddr),
    .byte_wdata_o(byte_wdata),
    .byte_re_o   (byte_re),
    .byte_raddr_o(byte_raddr),
    .byte_rdata_i(byte_rdata)
  );

  // Header memory: one entry per byte offset holding stamp, length and link.
  trrb_ram #(
    .WIDTH(HW),
    .DEPTH(BUFFER_BYTES)
  ) u_hdr_mem (
    .clk_i  (clk_i),
    .we_i   (hdr_we),
    .waddr_i(hdr_waddr),
    .wdata_i(hdr_wdata),
    .re_i   (hdr_re),
    .raddr_i(hdr_raddr),
    .rdata_o(hdr_rdata)
  );

  // Message byte store; its contents are undefined until written.
  trrb_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_byte_mem (
    .clk_i  (clk_i),
    .we_i   (byte_we),
    .waddr_i(byte_waddr),
    .wdata_i(byte_wdata),
    .re_i   (byte_re),
    .raddr_i(byte_raddr),
    .rdata_o(byte_rdata)
  );

  // The output register frees the sequencer as soon as a result is staged, so
  // it can take the next item while the consumer stalls.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

>>> rtl/core/trrb_ram.sv
module trrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/trrb_ctrl.sv
module trrb_ctrl
  import trrb_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = 4096,
  parameter int unsigned HEADER_BYTES = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  in_t                             in_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output out_t                            res_o,
  output logic                            hdr_we_o,
  output logic [$clog2(BUFFER_BYTES)-1:0] hdr_waddr_o,
  output logic [$clog2(BUFFER_BYTES)+76:0] hdr_wdata_o,
  output logic                            hdr_re_o,
  output logic [$clog2(BUFFER_BYTES)-1:0] hdr_raddr_o,
  input  logic [$clog2(BUFFER_BYTES)+76:0] hdr_rdata_i,
  output logic                            byte_we_o,
  output logic [$clog2(BUFFER_BYTES)-1:0] byte_waddr_o,
  output logic [7:0]                      byte_wdata_o,
  output logic                            byte_re_o,
  output logic [$clog2(BUFFER_BYTES)-1:0] byte_raddr_o,
  input  logic [7:0]                      byte_rdata_i
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned W  = AW + 1;
  localparam int unsigned PW = (AW + 2 > 14) ? AW + 2 : 14;
  localparam logic [PW-1:0] BB_P = PW'(BUFFER_BYTES);
  localparam logic [PW-1:0] HB_P = PW'(HEADER_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(BUFFER_BYTES - 1);

  state_e state_q, state_d;
  in_t    in_q, in_d;
  out_t   res_q, res_d;
  logic [W-1:0]  wp_q, wp_d;
  logic [AW-1:0] old_q, old_d, new_q, new_d, ptr_q, ptr_d, clr_q, clr_d;
  logic          old_v_q, old_v_d, new_v_q, new_v_d, ok_q, ok_d;
  logic [63:0]   new_stamp_q, new_stamp_d;
  logic [11:0]   new_len_q, new_len_d;

  // Fields of the header entry just read.
  logic [63:0]   r_stamp;
  logic [11:0]   r_len;
  logic [AW-1:0] r_next;
  logic          r_nv;

  logic [PW-1:0] len_p, idx_p, off_p, wp_p, total_p, bound_p, pos_wb, pos_rd, old_p;
  logic          order_bad, too_long, wraps, wb_bad, off_bad, evict_hit, rd_bad;

  assign r_stamp = hdr_rdata_i[AW+76:AW+13];
  assign r_len   = hdr_rdata_i[AW+12:AW+1];
  assign r_next  = hdr_rdata_i[AW:1];
  assign r_nv    = hdr_rdata_i[0];

  always_comb begin
    len_p     = PW'(in_q.message_length);
    idx_p     = PW'(in_q.byte_index);
    off_p     = PW'(in_q.record_offset);
    wp_p      = PW'(wp_q);
    old_p     = PW'(old_q);
    total_p   = HB_P + len_p;
    bound_p   = wp_p + total_p;
    pos_wb    = PW'(new_q) + HB_P + idx_p;
    pos_rd    = off_p + HB_P + idx_p;
    order_bad = new_v_q && (in_q.stamp < new_stamp_q);
    too_long  = total_p > BB_P;
    wraps     = bound_p > BB_P;
    wb_bad    = !new_v_q || (in_q.byte_index >= new_len_q) || (pos_wb >= BB_P);
    off_bad   = off_p >= BB_P;
    evict_hit = old_v_q && (old_p >= wp_p) && (old_p < bound_p);
    rd_bad    = (in_q.byte_index >= r_len) || (pos_rd >= BB_P);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == CLR_LAST) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISP;
      end
      S_DISP: begin
        case (in_q.operation)
          OP_APPEND: state_d = (order_bad || too_long) ? S_DONE : S_EV_CHK;
          OP_SEEK:   state_d = S_SK_ISS;
          OP_NEXT:   state_d = off_bad ? S_DONE : S_NX_EVAL;
          OP_READ:   state_d = off_bad ? S_DONE : S_RD_EVAL;
          default:   state_d = S_DONE;
        endcase
      end
      S_EV_CHK:  state_d = evict_hit ? S_EV_UPD : S_LINK;
      S_EV_UPD:  state_d = S_EV_CHK;
      S_LINK:    state_d = S_PLACE;
      S_PLACE:   state_d = S_DONE;
      S_SK_ISS:  state_d = ok_q ? S_SK_EVAL : S_DONE;
      S_SK_EVAL: state_d = (r_stamp < in_q.stamp) ? S_SK_ISS : S_DONE;
      S_NX_EVAL: state_d = r_nv ? S_NX_OUT : S_DONE;
      S_NX_OUT:  state_d = S_DONE;
      S_RD_EVAL: state_d = rd_bad ? S_DONE : S_RD_OUT;
      S_RD_OUT:  state_d = S_DONE;
      S_DONE: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default:   state_d = S_IDLE;
    endcase
  end

  // Handshake and memory controls.
  always_comb begin
    in_ready_o   = state_q == S_IDLE;
    res_valid_o  = state_q == S_DONE;
    hdr_we_o     = 1'b0;
    hdr_waddr_o  = clr_q;
    hdr_wdata_o  = '0;
    hdr_re_o     = 1'b0;
    hdr_raddr_o  = off_p[AW-1:0];
    byte_we_o    = 1'b0;
    byte_waddr_o = pos_wb[AW-1:0];
    byte_wdata_o = in_q.byte_value;
    byte_re_o    = 1'b0;
    byte_raddr_o = pos_rd[AW-1:0];
    case (state_q)
      S_CLEAR: hdr_we_o = 1'b1;
      S_DISP: begin
        hdr_re_o  = ((in_q.operation == OP_NEXT) || (in_q.operation == OP_READ)) && !off_bad;
        byte_we_o = (in_q.operation == OP_WRITE) && !wb_bad;
      end
      S_EV_CHK: begin
        hdr_re_o    = evict_hit;
        hdr_raddr_o = old_q;
      end
      S_LINK: begin
        hdr_we_o    = new_v_q;
        hdr_waddr_o = new_q;
        hdr_wdata_o = {new_stamp_q, new_len_q, wp_q[AW-1:0], 1'b1};
      end
      S_PLACE: begin
        hdr_we_o    = 1'b1;
        hdr_waddr_o = wp_q[AW-1:0];
        hdr_wdata_o = {in_q.stamp, in_q.message_length, {AW{1'b0}}, 1'b0};
      end
      S_SK_ISS: begin
        hdr_re_o    = ok_q;
        hdr_raddr_o = ptr_q;
      end
      S_NX_EVAL: begin
        hdr_re_o    = r_nv;
        hdr_raddr_o = r_next;
      end
      S_RD_EVAL: byte_re_o = !rd_bad;
      default: ;
    endcase
  end

  // Datapath register updates.
  always_comb begin
    in_d        = in_q;
    res_d       = res_q;
    wp_d        = wp_q;
    old_d       = old_q;
    old_v_d     = old_v_q;
    new_d       = new_q;
    new_v_d     = new_v_q;
    new_stamp_d = new_stamp_q;
    new_len_d   = new_len_q;
    ptr_d       = ptr_q;
    ok_d        = ok_q;
    clr_d       = clr_q;
    case (state_q)
      S_CLEAR: clr_d = clr_q + 1'b1;
      S_IDLE: begin
        if (in_valid_i) in_d = in_i;
      end
      S_DISP: begin
        res_d        = '0;
        res_d.status = ST_NONE;
        case (in_q.operation)
          OP_APPEND: begin
            if (order_bad) begin
              res_d.status = ST_ORDER;
            end else if (too_long) begin
              res_d.status = ST_LONG;
            end else if (wraps) begin
              // The record does not fit at the end: restart at the bottom.
              wp_d    = '0;
              old_d   = '0;
              old_v_d = 1'b1;
            end
          end
          OP_WRITE: begin
            if (!wb_bad) begin
              res_d.status       = ST_OK;
              res_d.found_offset = 12'(new_q);
            end
          end
          OP_SEEK: begin
            ptr_d = old_q;
            ok_d  = old_v_q;
          end
          default: ;
        endcase
      end
      S_EV_UPD: begin
        old_v_d = r_nv;
        old_d   = r_nv ? r_next : '0;
      end
      S_PLACE: begin
        new_d        = wp_q[AW-1:0];
        new_v_d      = 1'b1;
        new_stamp_d  = in_q.stamp;
        new_len_d    = in_q.message_length;
        wp_d         = W'(bound_p);
        if (!old_v_q) begin
          old_d   = wp_q[AW-1:0];
          old_v_d = 1'b1;
        end
        res_d.status       = ST_OK;
        res_d.found_offset = 12'(wp_q);
      end
      S_SK_EVAL: begin
        if (r_stamp < in_q.stamp) begin
          ok_d  = r_nv;
          ptr_d = r_nv ? r_next : '0;
        end else begin
          res_d.status       = ST_OK;
          res_d.found_offset = 12'(ptr_q);
          res_d.found_stamp  = r_stamp;
          res_d.found_length = r_len;
        end
      end
      S_NX_EVAL: ptr_d = r_next;
      S_NX_OUT: begin
        res_d.status       = ST_OK;
        res_d.found_offset = 12'(ptr_q);
        res_d.found_stamp  = r_stamp;
        res_d.found_length = r_len;
      end
      S_RD_OUT: begin
        res_d.status     = ST_OK;
        res_d.read_value = byte_rdata_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      wp_q    <= '0;
      old_q   <= '0;
      old_v_q <= 1'b0;
      new_q   <= '0;
      new_v_q <= 1'b0;
      ptr_q   <= '0;
      ok_q    <= 1'b0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      old_q   <= old_d;
      old_v_q <= old_v_d;
      new_q   <= new_d;
      new_v_q <= new_v_d;
      ptr_q   <= ptr_d;
      ok_q    <= ok_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q        <= in_d;
    res_q       <= res_d;
    new_stamp_q <= new_stamp_d;
    new_len_q   <= new_len_d;
  end

  assign res_o = res_q;

endmodule

>>> test/trrb_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the record ring buffer, predicts each result and
// compares it against what the block returns.
module trrb_checker
  import trrb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int unsigned STORE_BYTES = 4096;
  localparam int unsigned HDR_BYTES   = 24;

  logic [7:0]  store_mem [STORE_BYTES];
  logic [63:0] rec_stamp [STORE_BYTES];
  logic [11:0] rec_len   [STORE_BYTES];
  logic [11:0] rec_link  [STORE_BYTES];
  logic        rec_has_link [STORE_BYTES];

  int unsigned wr_pos;
  logic [11:0] head_off;
  logic        head_ok;
  logic [11:0] tail_off;
  logic        tail_ok;

  out_t expected_q[$];
  int   fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  initial begin
    fails    = 0;
    wr_pos   = 0;
    head_off = '0;
    head_ok  = 1'b0;
    tail_off = '0;
    tail_ok  = 1'b0;
    for (int i = 0; i < STORE_BYTES; i++) begin
      store_mem[i]    = '0;
      rec_stamp[i]    = '0;
      rec_len[i]      = '0;
      rec_link[i]     = '0;
      rec_has_link[i] = 1'b0;
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h, expected %0h", what, got, want);
    fails++;
  endtask

  function automatic out_t none_result();
    out_t r;
    r = '0;
    r.status = ST_NONE;
    return r;
  endfunction

  function automatic out_t record_result(input logic [11:0] off);
    out_t r;
    r = '0;
    r.status       = ST_OK;
    r.found_offset = off;
    r.found_stamp  = rec_stamp[off];
    r.found_length = rec_len[off];
    return r;
  endfunction

  // Append: order and size checks, wrap, eviction from the oldest end, then link.
  task automatic predict_append(input in_t it, output out_t r);
    int unsigned total;
    int unsigned bound;
    int unsigned guard;
    r = '0;
    total = HDR_BYTES + it.message_length;
    if (tail_ok && it.stamp < rec_stamp[tail_off]) begin
      r.status = ST_ORDER;
      return;
    end
    if (total > STORE_BYTES) begin
      r.status = ST_LONG;
      return;
    end
    if (wr_pos + total > STORE_BYTES) begin
      wr_pos   = 0;
      head_off = '0;
      head_ok  = 1'b1;
    end
    bound = wr_pos + total;
    guard = 0;
    while (head_ok && head_off >= wr_pos && head_off < bound && guard < STORE_BYTES) begin
      head_ok  = rec_has_link[head_off];
      head_off = head_ok ? rec_link[head_off] : '0;
      guard++;
    end
    if (tail_ok) begin
      rec_link[tail_off]     = wr_pos[11:0];
      rec_has_link[tail_off] = 1'b1;
    end
    rec_has_link[wr_pos] = 1'b0;
    rec_link[wr_pos]     = '0;
    rec_stamp[wr_pos]    = it.stamp;
    rec_len[wr_pos]      = it.message_length;
    tail_off = wr_pos[11:0];
    tail_ok  = 1'b1;
    wr_pos   = wr_pos + total;
    if (!head_ok) begin
      head_off = tail_off;
      head_ok  = 1'b1;
    end
    r.status       = ST_OK;
    r.found_offset = tail_off;
  endtask

  task automatic predict_seek(input logic [63:0] since, output out_t r);
    logic [11:0] p;
    logic        ok;
    int unsigned guard;
    p = head_off;
    ok = head_ok;
    guard = 0;
    while (ok && rec_stamp[p] < since && guard < STORE_BYTES) begin
      ok = rec_has_link[p];
      p  = ok ? rec_link[p] : '0;
      guard++;
    end
    if (ok && rec_stamp[p] >= since) r = record_result(p);
    else r = none_result();
  endtask

  task automatic predict_result(input in_t it, output out_t r);
    int unsigned pos;
    case (it.operation)
      OP_APPEND: predict_append(it, r);
      OP_WRITE: begin
        pos = tail_off + HDR_BYTES + it.byte_index;
        if (!tail_ok || it.byte_index >= rec_len[tail_off] || pos >= STORE_BYTES) begin
          r = none_result();
        end else begin
          store_mem[pos] = it.byte_value;
          r = '0;
          r.status       = ST_OK;
          r.found_offset = tail_off;
        end
      end
      OP_SEEK: predict_seek(it.stamp, r);
      OP_NEXT: begin
        if (!rec_has_link[it.record_offset]) r = none_result();
        else r = record_result(rec_link[it.record_offset]);
      end
      OP_READ: begin
        pos = it.record_offset + HDR_BYTES + it.byte_index;
        if (it.byte_index >= rec_len[it.record_offset] || pos >= STORE_BYTES) begin
          r = none_result();
        end else begin
          r = '0;
          r.status     = ST_OK;
          r.read_value = store_mem[pos];
        end
      end
      default: r = none_result();
    endcase
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      // The block cannot answer in the cycle it takes an item, so the input
      // side is handled first.
      if (in_valid_i && in_ready_i) begin
        predict_result(in_i, want);
        expected_q.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report("unexpected item", out_i.found_stamp, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_i.status != want.status)
            report("status", 64'(out_i.status), 64'(want.status));
          if (out_i.found_offset != want.found_offset)
            report("found_offset", 64'(out_i.found_offset), 64'(want.found_offset));
          if (out_i.found_stamp != want.found_stamp)
            report("found_stamp", out_i.found_stamp, want.found_stamp);
          if (out_i.found_length != want.found_length)
            report("found_length", 64'(out_i.found_length), 64'(want.found_length));
          if (out_i.read_value != want.read_value)
            report("read_value", 64'(out_i.read_value), 64'(want.read_value));
        end
      end
    end
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

// Top of the record ring buffer testbench. It only produces stimulus and
// gives the verdict; prediction and comparison live in the checker.
module tb_top;
  import trrb_pkg::*;

  localparam int unsigned STORE_BYTES = 4096;
  localparam int unsigned HDR_BYTES   = 24;
  localparam int unsigned RANDOM_ITEMS = 750;
  // Clearing pass plus worst-case chain walks and stalls, taken several times over.
  localparam int unsigned CYCLE_LIMIT = 1500000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_item;
  logic out_valid;
  logic out_ready;
  out_t out_item;
  int   fail_count;
  int   pending;

  // When quiet is set, neither side idles any more.
  logic        quiet;
  int unsigned cycles = 0;
  int unsigned sent;

  // A light shadow of the layout, kept only so that stimulus never reads a
  // message byte that was never written.
  int unsigned shadow_wp;
  logic        shadow_tail_ok;
  logic [11:0] shadow_tail;
  logic [11:0] shadow_tail_len;
  logic [63:0] shadow_tail_stamp;
  logic [11:0] shadow_len [STORE_BYTES];
  logic        shadow_written [STORE_BYTES];
  logic [11:0] recent_offsets[$];
  logic [63:0] next_stamp;

  timestamped_record_ring_buffer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_item)
  );

  trrb_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_i         (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_i        (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // The receiver stalls in random bursts, with long open stretches.
  always @(negedge clk) begin
    int unsigned hold;
    if (!rst_n) begin
      out_ready = 1'b0;
      hold = 0;
    end else if (quiet) begin
      out_ready = 1'b1;
    end else if (hold > 0) begin
      hold--;
      out_ready = (hold == 0);
    end else if ($urandom_range(0, 9) == 0) begin
      hold = $urandom_range(1, 6);
      out_ready = 1'b0;
    end else begin
      out_ready = 1'b1;
    end
  end

  // Keeps the shadow layout in step with an item that is about to go out.
  task automatic track_item(input in_t it);
    int unsigned total;
    int unsigned pos;
    total = HDR_BYTES + it.message_length;
    if (it.operation == OP_APPEND) begin
      if (shadow_tail_ok && it.stamp < shadow_tail_stamp) return;
      if (total > STORE_BYTES) return;
      if (shadow_wp + total > STORE_BYTES) shadow_wp = 0;
      shadow_tail       = shadow_wp[11:0];
      shadow_tail_len   = it.message_length;
      shadow_tail_stamp = it.stamp;
      shadow_tail_ok    = 1'b1;
      shadow_len[shadow_wp] = it.message_length;
      recent_offsets.push_back(shadow_tail);
      if (recent_offsets.size() > 48) void'(recent_offsets.pop_front());
      shadow_wp = shadow_wp + total;
    end else if (it.operation == OP_WRITE) begin
      pos = shadow_tail + HDR_BYTES + it.byte_index;
      if (shadow_tail_ok && it.byte_index < shadow_tail_len && pos < STORE_BYTES)
        shadow_written[pos] = 1'b1;
    end
  endtask

  // Drives one item from a falling edge and holds it until it is taken.
  task automatic send(input in_t it);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    track_item(it);
    @(negedge clk);
    in_item  = it;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  function automatic in_t blank_item(input op_e op);
    in_t it;
    it = '0;
    it.operation      = op;
    it.stamp          = {$urandom, $urandom};
    it.message_length = 12'($urandom);
    it.byte_value     = 8'($urandom);
    it.record_offset  = 12'($urandom);
    it.byte_index     = 12'($urandom);
    return it;
  endfunction

  task automatic send_append(input logic [63:0] st, input logic [11:0] len);
    in_t it;
    it = blank_item(OP_APPEND);
    it.stamp          = st;
    it.message_length = len;
    send(it);
  endtask

  task automatic send_write(input logic [11:0] idx);
    in_t it;
    it = blank_item(OP_WRITE);
    it.byte_index = idx;
    send(it);
  endtask

  task automatic send_seek(input logic [63:0] st);
    in_t it;
    it = blank_item(OP_SEEK);
    it.stamp = st;
    send(it);
  endtask

  task automatic send_next(input logic [11:0] off);
    in_t it;
    it = blank_item(OP_NEXT);
    it.record_offset = off;
    send(it);
  endtask

  // A read is steered off any byte that was never written by pushing the
  // index just past the message, which the block answers with no record.
  task automatic send_read(input logic [11:0] off, input logic [11:0] idx);
    in_t it;
    int unsigned pos;
    pos = off + HDR_BYTES + idx;
    if (idx < shadow_len[off] && pos < STORE_BYTES && !shadow_written[pos])
      idx = shadow_len[off];
    it = blank_item(OP_READ);
    it.record_offset = off;
    it.byte_index    = idx;
    send(it);
  endtask

  function automatic logic [11:0] pick_offset();
    if (recent_offsets.size() == 0 || $urandom_range(0, 4) == 0) return 12'($urandom);
    return recent_offsets[$urandom_range(0, recent_offsets.size() - 1)];
  endfunction

  // A whole record: header, then its message bytes, now and then a few skipped.
  // A long message only gets its first and last 16 bytes.
  task automatic send_record(input logic [11:0] len);
    logic skip;
    skip = ($urandom_range(0, 9) == 0);
    send_append(next_stamp, len);
    for (int i = 0; i < len; i++)
      if ((len <= 32 || i < 16 || i >= len - 16) && (!skip || $urandom_range(0, 2) != 0))
        send_write(12'(i));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    logic [11:0] off;
    int unsigned pick;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    quiet     = 1'b0;
    sent      = 0;
    shadow_wp = 0;
    shadow_tail_ok    = 1'b0;
    shadow_tail       = '0;
    shadow_tail_len   = '0;
    shadow_tail_stamp = '0;
    next_stamp = 64'd10;
    for (int i = 0; i < STORE_BYTES; i++) begin
      shadow_len[i]     = '0;
      shadow_written[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. On an empty store every query finds nothing.
    send_write(0);
    send_seek(64'd0);
    send_next(12'd0);
    send_read(12'd0, 12'd0);
    send(blank_item(op_e'(3'd5)));
    send(blank_item(op_e'(3'd6)));
    send(blank_item(op_e'(3'd7)));
    // An empty message, then two records too long for the store.
    send_append(64'd0, 12'd0);
    send_write(0);
    send_append(64'd1, 12'd4073);
    send_append(64'd1, 12'hfff);
    // The largest record wraps to the start and evicts everything before it.
    send_append(64'd5, 12'd4072);
    send_write(12'd4071);
    send_write(12'd0);
    send_write(12'd4072);
    send_read(12'd0, 12'd4071);
    send_read(12'd0, 12'd0);
    send_read(12'd0, 12'd4072);
    // A stamp older than the newest record is refused.
    send_append(64'd1, 12'd3);
    send_seek(64'd0);
    send_seek(64'd6);
    send_next(12'd0);
    // The store is full, so this one wraps again and evicts the big record.
    send_append(64'd5, 12'd2);
    send_write(0);
    send_write(1);

    // Random part: mostly whole records with queries mixed in.
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (sent > RANDOM_ITEMS / 2 && sent < RANDOM_ITEMS / 2 + 20) begin
        // The sender holds off here until every result is back.
        wait_drained();
      end
      if (sent > RANDOM_ITEMS * 9 / 10) quiet = 1'b1;
      if (pick < 40) begin
        next_stamp = next_stamp + $urandom_range(0, 1000);
        if ($urandom_range(0, 60) == 0) send_record(12'($urandom_range(600, 4072)));
        else send_record(12'($urandom_range(0, 24)));
      end else if (pick < 45) begin
        // Out of order, or too long.
        if ($urandom_range(0, 1) == 0) send_append(next_stamp - $urandom_range(1, 50), 4);
        else send_append(next_stamp, 12'($urandom_range(4073, 4095)));
      end else if (pick < 60) begin
        if ($urandom_range(0, 3) == 0) send_seek({$urandom, $urandom});
        else send_seek(next_stamp - $urandom_range(0, 20000));
      end else if (pick < 72) begin
        send_next(pick_offset());
      end else if (pick < 90) begin
        off = pick_offset();
        send_read(off, 12'($urandom_range(0, shadow_len[off] + 2)));
      end else if (pick < 95) begin
        send_write(12'($urandom_range(0, 40)));
      end else begin
        send(blank_item(op_e'(3'($urandom_range(5, 7)))));
      end
    end

    // The largest stamp closes the run; nothing may follow it in time.
    send_append(64'hffff_ffff_ffff_ffff, 12'd1);
    send_write(0);
    send_seek(64'hffff_ffff_ffff_ffff);
    send_append(64'hffff_ffff_ffff_fffe, 12'd1);
    @(negedge clk);
    in_valid = 1'b0;

    wait_drained();
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
